FILE: hdl/olrb_pkg.sv
// ----------------------------------------------------------------------------
// olrb_pkg
// Shared types and constants for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
package olrb_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // level stored when the caller gives none
    localparam logic [7:0] LEVEL_NONE = 8'h4E;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] time_stamp;
        logic [7:0]  level_char;
        logic [63:0] tag_word;
        logic [63:0] message_word;
        logic [7:0]  max_lines;
    } cmd_t;

    typedef struct packed {
        logic [31:0] time_stamp;
        logic [7:0]  level_char;
        logic [63:0] tag_word;
        logic [63:0] message_word;
    } entry_t;

endpackage

FILE: hdl/overwriting_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_log_ring_buffer
// Circular trace store with overwrite of the oldest entry and oldest-first dump.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries commands: append (store one entry), dump (emit up to
//   s_max_lines held entries, oldest first) and clear. Opcode 3 is taken and
//   dropped. m_* carries one beat per dumped entry, m_last on the final one.
//   Commands pass through a two-entry queue, so s_ready falls only when the
//   queue is full, typically while a dump is still streaming.
//   A command is registered in the queue before it reaches the executor. A
//   dump enters the dump state and then reads the entry memory once per
//   entry, through its single read port, into the output register that
//   drives m_*. The executor takes no new command until the last entry of a
//   dump has been read; append and clear finish without leaving idle.
//   Reset empties the store (pointer and fill count to zero); entry contents
//   are not cleared. When m_ready is low the current beat holds and the dump
//   pauses; queued commands wait behind it.
// ----------------------------------------------------------------------------
module overwriting_log_ring_buffer #(
    parameter int DEPTH = olrb_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_time_stamp,
    input  logic [7:0]  s_level_char,
    input  logic [63:0] s_tag_word,
    input  logic [63:0] s_message_word,
    input  logic [7:0]  s_max_lines,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_time,
    output logic [7:0]  m_out_level,
    output logic [63:0] m_out_tag,
    output logic [63:0] m_out_message,
    output logic        m_last
);

    logic           push_valid, push_ready;
    olrb_pkg::cmd_t push_cmd;
    logic           pop_valid, pop_ready;
    olrb_pkg::cmd_t pop_cmd;

    olrb_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_time_stamp   (s_time_stamp),
        .s_level_char   (s_level_char),
        .s_tag_word     (s_tag_word),
        .s_message_word (s_message_word),
        .s_max_lines    (s_max_lines),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    olrb_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    olrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd_ready     (pop_ready),
        .cmd           (pop_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_time    (m_out_time),
        .m_out_level   (m_out_level),
        .m_out_tag     (m_out_tag),
        .m_out_message (m_out_message),
        .m_last        (m_last)
    );

endmodule

FILE: hdl/olrb_front.sv
// ----------------------------------------------------------------------------
// olrb_front
// Input side: accepts beats, drops unknown opcodes and normalises the level.
// ----------------------------------------------------------------------------
module olrb_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [31:0]        s_time_stamp,
    input  logic [7:0]         s_level_char,
    input  logic [63:0]        s_tag_word,
    input  logic [63:0]        s_message_word,
    input  logic [7:0]         s_max_lines,
    output logic               push_valid,
    input  logic               push_ready,
    output olrb_pkg::cmd_t     push_cmd
);

    logic known_op;

    always_comb begin
        case (s_opcode)
            olrb_pkg::OP_APPEND,
            olrb_pkg::OP_DUMP,
            olrb_pkg::OP_CLEAR: known_op = 1'b1;
            default:            known_op = 1'b0;
        endcase
    end

    assign s_ready    = push_ready;
    // drop unknown opcodes at the door; they still take a beat
    assign push_valid = s_valid & known_op;

    always_comb begin
        push_cmd.opcode       = s_opcode;
        push_cmd.time_stamp   = s_time_stamp;
        push_cmd.level_char   = (s_level_char == 8'd0) ? olrb_pkg::LEVEL_NONE : s_level_char;
        push_cmd.tag_word     = s_tag_word;
        push_cmd.message_word = s_message_word;
        push_cmd.max_lines    = s_max_lines;
    end

endmodule

FILE: hdl/olrb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// olrb_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module olrb_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  olrb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output olrb_pkg::cmd_t pop_cmd
);

    olrb_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/olrb_back.sv
// ----------------------------------------------------------------------------
// olrb_back
// Executes queued commands against the entry memory and streams dumps.
// ----------------------------------------------------------------------------
module olrb_back #(
    parameter int DEPTH = olrb_pkg::DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  olrb_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_out_time,
    output logic [7:0]     m_out_level,
    output logic [63:0]    m_out_tag,
    output logic [63:0]    m_out_message,
    output logic           m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    olrb_pkg::entry_t mem [DEPTH];
    olrb_pkg::entry_t rd_q_reg;

    logic          state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          valid_reg, valid_next;
    logic          last_reg;

    logic          take;
    logic          wr_en;
    logic          rd_en;
    logic [CW-1:0] dump_len;
    logic [AW-1:0] dump_start;
    logic [SW-1:0] wp_ext, fill_ext;
    logic [AW-1:0] wp_inc, addr_inc;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid & cmd_ready;
    assign wr_en     = take & (cmd.opcode == olrb_pkg::OP_APPEND);
    // output register doubles as the read data register
    assign rd_en     = (state_reg == ST_DUMP) & (~valid_reg | m_ready);

    assign wp_ext   = SW'(wp_reg);
    assign fill_ext = SW'(fill_reg);
    assign wp_inc   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign addr_inc = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;

    always_comb begin
        if (cmd.max_lines < 8'(fill_reg)) begin
            dump_len = CW'(cmd.max_lines);
        end else begin
            dump_len = fill_reg;
        end
        if (wp_ext >= fill_ext) begin
            dump_start = AW'(wp_ext - fill_ext);
        end else begin
            dump_start = AW'(wp_ext + SW'(DEPTH) - fill_ext);
        end
    end

    always_comb begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        if (take) begin
            case (cmd.opcode)
                olrb_pkg::OP_APPEND: begin
                    wp_next = wp_inc;
                    if (fill_reg != CW'(DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                olrb_pkg::OP_DUMP: begin
                    if (dump_len != '0) begin
                        addr_next   = dump_start;
                        remain_next = dump_len;
                        state_next  = ST_DUMP;
                    end
                end
                olrb_pkg::OP_CLEAR: begin
                    wp_next   = '0;
                    fill_next = '0;
                end
                default: ;
            endcase
        end
        if (rd_en) begin
            addr_next   = addr_inc;
            remain_next = remain_reg - 1'b1;
            if (remain_reg == CW'(1)) begin
                state_next = ST_IDLE;
            end
        end
        if (rd_en) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            addr_reg   <= '0;
            remain_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            addr_reg   <= addr_next;
            remain_reg <= remain_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= '{time_stamp:   cmd.time_stamp,
                             level_char:   cmd.level_char,
                             tag_word:     cmd.tag_word,
                             message_word: cmd.message_word};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem[addr_reg];
            last_reg <= (remain_reg == CW'(1));
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_time    = rd_q_reg.time_stamp;
    assign m_out_level   = rd_q_reg.level_char;
    assign m_out_tag     = rd_q_reg.tag_word;
    assign m_out_message = rd_q_reg.message_word;
    assign m_last        = last_reg;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the entry store, the write pointer and
// the fill count. It works out the beats of every accepted dump and compares
// each emitted beat field by field, in order. Stimulus starts with a directed
// pass over the edge cases: empty dump, zero count, level of zero and
// clear. Random traffic follows, including a long receiver hold-off that
// backs up the command queue. The sender runs in bursts and the receiver
// stalls on a changing pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         DEPTH         = olrb_pkg::DEPTH_DEFAULT;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         TIMEOUT_TICKS = 16_000_000;

    typedef struct packed {
        olrb_pkg::entry_t entry;
        logic             last;
    } dump_beat_t;

    class trace_scoreboard;
        olrb_pkg::entry_t held[DEPTH];
        int               wr_ptr;
        int               fill;
        dump_beat_t       due[$];
        int               errors;

        function new();
            wr_ptr = 0;
            fill   = 0;
            errors = 0;
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        function int pending();
            return due.size();
        endfunction

        function void note_command(olrb_pkg::cmd_t c);
            int         n;
            int         first;
            dump_beat_t b;
            case (c.opcode)
                olrb_pkg::OP_APPEND: begin
                    held[wr_ptr].time_stamp   = c.time_stamp;
                    held[wr_ptr].level_char   = (c.level_char == 8'd0) ? olrb_pkg::LEVEL_NONE
                                                                        : c.level_char;
                    held[wr_ptr].tag_word     = c.tag_word;
                    held[wr_ptr].message_word = c.message_word;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    if (fill < DEPTH) fill++;
                end
                olrb_pkg::OP_DUMP: begin
                    n     = (int'(c.max_lines) < fill) ? int'(c.max_lines) : fill;
                    first = (wr_ptr + DEPTH - fill) % DEPTH;
                    for (int i = 0; i < n; i++) begin
                        b.entry = held[(first + i) % DEPTH];
                        b.last  = (i == n - 1);
                        due.insert(due.size(), b);
                    end
                end
                olrb_pkg::OP_CLEAR: begin
                    wr_ptr = 0;
                    fill   = 0;
                end
                default: ;
            endcase
        endfunction

        task check_result(olrb_pkg::entry_t got, logic got_last);
            dump_beat_t exp;
            if (due.size() == 0) begin
                report($sformatf("beat with nothing due: time %h tag %h", got.time_stamp,
                                 got.tag_word));
            end else begin
                exp = due.pop_front();
                if (got.time_stamp != exp.entry.time_stamp)
                    report($sformatf("out_time %h, wanted %h", got.time_stamp,
                                     exp.entry.time_stamp));
                if (got.level_char != exp.entry.level_char)
                    report($sformatf("out_level %h, wanted %h", got.level_char,
                                     exp.entry.level_char));
                if (got.tag_word != exp.entry.tag_word)
                    report($sformatf("out_tag %h, wanted %h", got.tag_word,
                                     exp.entry.tag_word));
                if (got.message_word != exp.entry.message_word)
                    report($sformatf("out_message %h, wanted %h", got.message_word,
                                     exp.entry.message_word));
                if (got_last != exp.last)
                    report($sformatf("last %b, wanted %b", got_last, exp.last));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_time_stamp;
    logic [7:0]  s_level_char;
    logic [63:0] s_tag_word;
    logic [63:0] s_message_word;
    logic [7:0]  s_max_lines;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_time;
    logic [7:0]  m_out_level;
    logic [63:0] m_out_tag;
    logic [63:0] m_out_message;
    logic        m_last;

    bit              hold_req;
    trace_scoreboard sb;

    overwriting_log_ring_buffer #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_time_stamp  (s_time_stamp),
        .s_level_char  (s_level_char),
        .s_tag_word    (s_tag_word),
        .s_message_word(s_message_word),
        .s_max_lines   (s_max_lines),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_time    (m_out_time),
        .m_out_level   (m_out_level),
        .m_out_tag     (m_out_tag),
        .m_out_message (m_out_message),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic olrb_pkg::cmd_t make_cmd(logic [1:0] op, logic [31:0] ts,
                                                logic [7:0] lvl, logic [63:0] tag,
                                                logic [63:0] msg, logic [7:0] lines);
        olrb_pkg::cmd_t c;
        c.opcode       = op;
        c.time_stamp   = ts;
        c.level_char   = lvl;
        c.tag_word     = tag;
        c.message_word = msg;
        c.max_lines    = lines;
        return c;
    endfunction

    function automatic olrb_pkg::cmd_t random_cmd(logic [1:0] op);
        olrb_pkg::cmd_t c;
        int             sel;
        c.opcode       = op;
        c.time_stamp   = $urandom;
        sel            = $urandom_range(0, 9);
        c.level_char   = (sel == 0) ? 8'd0 : 8'($urandom);
        c.tag_word     = {$urandom, $urandom};
        c.message_word = {$urandom, $urandom};
        sel            = $urandom_range(0, 9);
        case (sel)
            0:       c.max_lines = 8'd0;
            1:       c.max_lines = 8'd255;
            2:       c.max_lines = 8'($urandom_range(0, 255));
            3:       c.max_lines = 8'($urandom_range(62, 66));
            default: c.max_lines = 8'($urandom_range(1, 40));
        endcase
        return c;
    endfunction

    task send_cmd(olrb_pkg::cmd_t c);
        @(negedge aclk);
        s_valid        = 1'b1;
        s_opcode       = c.opcode;
        s_time_stamp   = c.time_stamp;
        s_level_char   = c.level_char;
        s_tag_word     = c.tag_word;
        s_message_word = c.message_word;
        s_max_lines    = c.max_lines;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(c);
    endtask

    task idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    task wait_drained();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Opcode 3 beats are sent as noise but do not count towards the total.
    task random_traffic(int count, int clear_pct, int dump_pct);
        int         done;
        int         burst_left;
        int         r;
        logic [1:0] op;
        done       = 0;
        burst_left = 0;
        while (done < count) begin
            if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 16);
            end
            r = $urandom_range(0, 99);
            if (r < 4)                             op = OP_UNUSED;
            else if (r < 4 + clear_pct)            op = olrb_pkg::OP_CLEAR;
            else if (r < 4 + clear_pct + dump_pct) op = olrb_pkg::OP_DUMP;
            else                                   op = olrb_pkg::OP_APPEND;
            send_cmd(random_cmd(op));
            burst_left--;
            if (op != OP_UNUSED) done++;
        end
    endtask

    // Receiver: stall pattern changes every so often; a hold request parks it.
    initial begin
        int mode;
        int mode_left;
        m_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    2:       m_ready = ($urandom_range(0, 7) != 0);
                    default: m_ready = (mode_left % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_out_time, m_out_level, m_out_tag, m_out_message}, m_last);
    end

    initial begin
        #(TIMEOUT_TICKS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb             = new();
        hold_req       = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = olrb_pkg::OP_APPEND;
        s_time_stamp   = '0;
        s_level_char   = '0;
        s_tag_word     = '0;
        s_message_word = '0;
        s_max_lines    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        idle_cycles(3);

        // directed: empty store, level of zero, field extremes, count clamping
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd8));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, '0, 8'd0, '0, '0, '0));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, '1, 8'hFF, '1, '1, '1));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, 32'h0001_2345, 8'h49,
                          64'h5441_4731_0000_0000, 64'h0123_4567_89AB_CDEF, 8'd0));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '1, '1, '1, '1, 8'd0));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd1));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd255));
        send_cmd(make_cmd(OP_UNUSED, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd3));
        idle_cycles(2);
        send_cmd(make_cmd(olrb_pkg::OP_CLEAR, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd255));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, 32'h8000_0000, 8'h80,
                          64'h8000_0000_0000_0001, 64'hAAAA_5555_AAAA_5555, 8'h80));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, 32'h7FFF_FFFF, 8'h01,
                          64'h7FFF_FFFF_FFFF_FFFE, 64'h5555_AAAA_5555_AAAA, 8'h7F));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd2));
        send_cmd(make_cmd(olrb_pkg::OP_APPEND, 32'h0000_0001, 8'h57, 64'h1, 64'h2, 8'h01));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd2));
        send_cmd(make_cmd(olrb_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(olrb_pkg::OP_DUMP, '0, '0, '0, '0, 8'd1));
        wait_drained();

        // long runs between clears so the store wraps and saturates
        random_traffic(190, 1, 22);

        // park the receiver and keep pushing dumps until the queue backs up
        hold_req = 1'b1;
        repeat (10) begin
            send_cmd(random_cmd(olrb_pkg::OP_APPEND));
            send_cmd(make_cmd(olrb_pkg::OP_DUMP, $urandom, 8'($urandom),
                              {$urandom, $urandom}, {$urandom, $urandom}, 8'd255));
        end
        wait_drained();

        random_traffic(170, 4, 35);
        idle_cycles($urandom_range(1, 5));
        random_traffic(70, 0, 15);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d dump beats never emitted", sb.pending()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: overwriting_log_ring_buffer.f
hdl/olrb_pkg.sv
hdl/olrb_front.sv
hdl/olrb_cmd_fifo.sv
hdl/olrb_back.sv
hdl/overwriting_log_ring_buffer.sv
verif/testbench.sv
